// ----- hdl/b64c_pkg.sv -----
`default_nettype none

package b64c_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic       bad_char;
  } out_item_t;

  // All results that one input item causes, in order, up to last_idx.
  typedef struct packed {
    out_item_t [MaxResults-1:0] res;
    logic [$clog2(MaxResults)-1:0] last_idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic out_item_t make_res(logic [7:0] b, logic has, logic last, logic bad);
    out_item_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.out_last = last;
    r.bad_char = bad;
    return r;
  endfunction

  function automatic logic [7:0] sextet_char(logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h47 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'h04;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Returns {in_alphabet, value}.
  function automatic logic [6:0] char_sextet(logic [7:0] ch);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'h00;
    r = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      t = ch - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      t = ch - 8'h47;
      r = {1'b1, t[5:0]};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch + 8'h04;
      r = {1'b1, t[5:0]};
    end else if (ch == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (ch == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/b64c_front.sv -----
`default_nettype none

module b64c_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire b64c_pkg::in_item_t in_item_i,
  input  wire b64c_pkg::queue_status_t q_status_i,
  output logic                    push_o,
  output b64c_pkg::job_t          job_o
);
  import b64c_pkg::*;

  logic       mode_q;
  logic [5:0] store_q, store_d;
  logic [2:0] fill_q, fill_d;
  logic       pad_q, pad_d;
  logic       failed_q, failed_d;
  logic       accept;
  logic       has_res;
  logic [7:0] b;
  logic       eom;
  logic [11:0] enc_acc;
  logic [11:0] dec_acc;
  logic [6:0] sx;
  out_item_t  eq_res;

  assign accept = in_valid_i && !q_status_i.full;
  assign b      = in_item_i.data_byte;
  assign eom    = in_item_i.end_of_message;
  assign enc_acc = {store_q[3:0], b};
  assign sx      = char_sextet(b);
  assign dec_acc = {store_q, sx[5:0]};
  assign eq_res  = make_res(PadChar, 1'b1, 1'b0, 1'b0);

  always_comb begin
    job_o.res      = '0;
    job_o.last_idx = '0;
    has_res  = 1'b0;
    store_d  = store_q;
    fill_d   = fill_q;
    pad_d    = pad_q;
    failed_d = failed_q;
    if (mode_q == ModeEncode) begin
      has_res = 1'b1;
      unique case (fill_q)
        3'd2: begin
          job_o.res[0] = make_res(sextet_char(enc_acc[9:4]), 1'b1, 1'b0, 1'b0);
          store_d = {2'b00, enc_acc[3:0]};
          fill_d  = 3'd4;
          if (eom) begin
            job_o.res[1] = make_res(sextet_char({enc_acc[3:0], 2'b00}), 1'b1, 1'b0, 1'b0);
            job_o.res[2] = make_res(PadChar, 1'b1, 1'b1, 1'b0);
            job_o.last_idx = 2'd2;
          end
        end
        3'd4: begin
          job_o.res[0] = make_res(sextet_char(enc_acc[11:6]), 1'b1, 1'b0, 1'b0);
          job_o.res[1] = make_res(sextet_char(enc_acc[5:0]), 1'b1, eom, 1'b0);
          job_o.last_idx = 2'd1;
          store_d = '0;
          fill_d  = 3'd0;
        end
        default: begin
          job_o.res[0] = make_res(sextet_char(enc_acc[7:2]), 1'b1, 1'b0, 1'b0);
          store_d = {4'b0000, enc_acc[1:0]};
          fill_d  = 3'd2;
          if (eom) begin
            job_o.res[1] = make_res(sextet_char({enc_acc[1:0], 4'b0000}), 1'b1, 1'b0, 1'b0);
            job_o.res[2] = eq_res;
            job_o.res[3] = make_res(PadChar, 1'b1, 1'b1, 1'b0);
            job_o.last_idx = 2'd3;
          end
        end
      endcase
    end else begin
      if (!failed_q && !pad_q) begin
        if (b == PadChar) begin
          pad_d = 1'b1;
        end else if (!sx[6]) begin
          failed_d = 1'b1;
          has_res  = 1'b1;
          job_o.res[0] = make_res(8'h00, 1'b0, eom, 1'b1);
        end else begin
          unique case (fill_q)
            3'd6: begin
              has_res = 1'b1;
              job_o.res[0] = make_res(dec_acc[11:4], 1'b1, eom, 1'b0);
              store_d = {2'b00, dec_acc[3:0]};
              fill_d  = 3'd4;
            end
            3'd4: begin
              has_res = 1'b1;
              job_o.res[0] = make_res(dec_acc[9:2], 1'b1, eom, 1'b0);
              store_d = {4'b0000, dec_acc[1:0]};
              fill_d  = 3'd2;
            end
            3'd2: begin
              has_res = 1'b1;
              job_o.res[0] = make_res(dec_acc[7:0], 1'b1, eom, 1'b0);
              store_d = '0;
              fill_d  = 3'd0;
            end
            default: begin
              store_d = sx[5:0];
              fill_d  = 3'd6;
            end
          endcase
        end
      end
      if (eom && !has_res) begin
        has_res = 1'b1;
        job_o.res[0] = make_res(8'h00, 1'b0, 1'b1, failed_q);
      end
    end
    if (eom) begin
      store_d  = '0;
      fill_d   = '0;
      pad_d    = 1'b0;
      failed_d = 1'b0;
    end
  end

  assign push_o = accept && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeEncode;
      store_q  <= '0;
      fill_q   <= '0;
      pad_q    <= 1'b0;
      failed_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q   <= cfg_wdata_i;
      store_q  <= '0;
      fill_q   <= '0;
      pad_q    <= 1'b0;
      failed_q <= 1'b0;
    end else if (accept) begin
      store_q  <= store_d;
      fill_q   <= fill_d;
      pad_q    <= pad_d;
      failed_q <= failed_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/b64c_queue.sv -----
`default_nettype none

module b64c_queue #(
  parameter int unsigned Depth = b64c_pkg::QueueDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b64c_pkg::job_t push_job_i,
  input  wire logic           pop_i,
  output b64c_pkg::job_t      head_job_o,
  output b64c_pkg::queue_status_t status_o
);
  import b64c_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_job_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/b64c_back.sv -----
`default_nettype none

module b64c_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire b64c_pkg::job_t          head_job_i,
  input  wire b64c_pkg::queue_status_t q_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output b64c_pkg::out_item_t          out_item_o
);
  import b64c_pkg::*;

  job_t                          job_q;
  logic                          job_valid_q;
  logic [$clog2(MaxResults)-1:0] idx_q;
  out_item_t                     out_q;
  logic                          out_valid_q;
  logic                          out_free;
  logic                          emit;
  logic                          job_done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = job_valid_q && out_free;
  assign job_done = emit && (idx_q == job_q.last_idx);
  assign pop_o    = !q_status_i.empty && (!job_valid_q || job_done);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_job_i;
    end
    if (emit) begin
      out_q <= job_q.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (job_done) begin
        job_valid_q <= 1'b0;
        idx_q       <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/base64_codec_unit.sv -----
// Streaming base64 encoder and decoder with the standard alphabet.
// cfg_we_i writes cfg_wdata_i into the mode register (0 encode, 1 decode) and
// abandons any message in progress; write it only while the block is idle.
// The input channel takes one byte or character per item with an end of
// message flag. The output channel gives characters or decoded bytes, with
// has_byte, out_last and bad_char flags; one input item yields up to four
// output items.
// The front end accepts an item in any cycle in which the job queue has room
// and turns it into a job holding all of its results. The back end drains one
// result per cycle into the output register, so the output port sets the
// rate: one output item per cycle while the receiver does not stall.
// Mid-message encoding gives four characters per three bytes, and a byte
// that completes a group yields two of them. Decoding gives at most one
// byte per character. An item's results pass through a queue slot, the back
// end's job register and the output register.
// Reset clears the mode to encode, the message state and the queue. When the
// receiver stalls, the output item holds, the queue fills, and in_stall_o
// rises once the queue is full.
`default_nettype none

module base64_codec_unit #(
  parameter int unsigned QueueDepth = b64c_pkg::QueueDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire b64c_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output b64c_pkg::out_item_t      out_item_o
);
  import b64c_pkg::*;

  logic          push, pop;
  job_t          push_job, head_job;
  queue_status_t q_status;

  assign in_stall_o = q_status.full;

  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .status_o   (q_status)
  );

  b64c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- hdl/b64c_checker.sv -----
`default_nettype none

module b64c_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_we_i,
  input wire logic                cfg_wdata_i,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire b64c_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire b64c_pkg::out_item_t out_item_o
);
  import b64c_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ cfg_wdata_i ^ in_valid_i ^ in_stall_o ^ (^in_item_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.has_byte |-> out_item_o.out_byte == 8'h00)
    else $error("result without data carries a nonzero byte");

  a_bad_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_char |-> !out_item_o.has_byte)
    else $error("error result carries data");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.has_byte && !out_item_o.bad_char |-> out_item_o.out_last)
    else $error("bare end marker without last flag");

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (.*);

`default_nettype wire

// ----- verif/base64_codec_unit_tb.sv -----
`timescale 1ns / 100ps

module base64_codec_unit_tb;
  import b64c_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 12;
  localparam int BurstCycles = 80;
  localparam int ChunkItems = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_item_t in_item = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_item_t out_item_o;

  in_item_t pending_items[$];
  out_item_t due_results[$];

  int tx_idle_pct = 34;
  int rx_idle_pct = 88;
  int burst_req = 0;
  int burst_seen = 0;
  int burst_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  logic codec_mode = ModeEncode;
  logic [11:0] held_bits = '0;
  logic [2:0] held_count = '0;
  logic pad_met = 1'b0;
  logic msg_bad = 1'b0;

  base64_codec_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] b64_letter(input logic [5:0] v);
    int c;
    if (v < 26) begin
      c = 8'h41 + int'(v);
    end else if (v < 52) begin
      c = 8'h61 + int'(v) - 26;
    end else if (v < 62) begin
      c = 8'h30 + int'(v) - 52;
    end else if (v == 62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return 8'(c);
  endfunction

  function automatic int char_value(input logic [7:0] ch);
    int v;
    v = -1;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = int'(ch) - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = int'(ch) - 8'h61 + 26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = int'(ch) - 8'h30 + 52;
    end else if (ch == 8'h2B) begin
      v = 62;
    end else if (ch == 8'h2F) begin
      v = 63;
    end
    return v;
  endfunction

  function automatic out_item_t result_of(input logic [7:0] b, input logic has,
                                          input logic last, input logic bad);
    out_item_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.out_last = last;
    r.bad_char = bad;
    return r;
  endfunction

  task automatic clear_message();
    held_bits = '0;
    held_count = '0;
    pad_met = 1'b0;
    msg_bad = 1'b0;
  endtask

  // Works out every result that one accepted item causes and queues them.
  task automatic codec_step(input in_item_t it);
    out_item_t res[4];
    int n;
    int bits;
    int v;
    logic [11:0] acc;
    logic eom;
    logic done;
    n = 0;
    done = 1'b0;
    eom = it.end_of_message;
    if (codec_mode == ModeEncode) begin
      acc = {held_bits[3:0], it.data_byte};
      bits = int'(held_count) + 8;
      if (bits > 12) bits = 12;
      while (bits >= 6) begin
        bits = bits - 6;
        res[n] = result_of(b64_letter(6'(acc >> bits)), 1'b1, 1'b0, 1'b0);
        n = n + 1;
      end
      acc = acc & ((12'd1 << bits) - 12'd1);
      if (eom) begin
        if (bits == 2) begin
          res[n] = result_of(b64_letter(6'(acc << 4)), 1'b1, 1'b0, 1'b0);
          res[n+1] = result_of(PadChar, 1'b1, 1'b0, 1'b0);
          res[n+2] = result_of(PadChar, 1'b1, 1'b1, 1'b0);
          n = n + 3;
        end else if (bits == 4) begin
          res[n] = result_of(b64_letter(6'(acc << 2)), 1'b1, 1'b0, 1'b0);
          res[n+1] = result_of(PadChar, 1'b1, 1'b1, 1'b0);
          n = n + 2;
        end else begin
          res[n-1].out_last = 1'b1;
        end
        clear_message();
      end else begin
        held_bits = acc;
        held_count = 3'(bits);
      end
    end else begin
      if (!msg_bad && !pad_met) begin
        if (it.data_byte == PadChar) begin
          pad_met = 1'b1;
        end else begin
          v = char_value(it.data_byte);
          if (v < 0) begin
            msg_bad = 1'b1;
            res[n] = result_of(8'h00, 1'b0, eom, 1'b1);
            n = n + 1;
            if (eom) clear_message();
            done = 1'b1;
          end else begin
            acc = {held_bits[5:0], 6'(v)};
            bits = int'(held_count) + 6;
            if (bits > 12) bits = 12;
            if (bits >= 8) begin
              bits = bits - 8;
              res[n] = result_of(8'(acc >> bits), 1'b1, eom, 1'b0);
              n = n + 1;
            end
            held_bits = acc & ((12'd1 << bits) - 12'd1);
            held_count = 3'(bits);
          end
        end
      end
      if (eom && !done) begin
        if (n == 0) begin
          res[n] = result_of(8'h00, 1'b0, 1'b1, msg_bad);
          n = n + 1;
        end
        clear_message();
      end
    end
    for (int i = 0; i < n; i++) due_results.insert(due_results.size(), res[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      codec_mode = ModeEncode;
      clear_message();
    end else begin
      taken = in_valid && !in_stall_o;
      if (cfg_we) begin
        codec_mode = cfg_wdata;
        clear_message();
      end
      if (taken) begin
        codec_step(in_item);
        void'(pending_items.pop_front());
      end
      if (!in_valid || taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_error(input string what, input out_item_t want, input out_item_t got);
    error_count = error_count + 1;
    if (error_count <= 10) begin
      $display("%s: expected byte %h has %b last %b bad %b, got byte %h has %b last %b bad %b",
               what, want.out_byte, want.has_byte, want.out_last, want.bad_char,
               got.out_byte, got.has_byte, got.out_last, got.bad_char);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    out_item_t want;
    logic hold;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (due_results.size() == 0) begin
          note_error("unexpected result", '0, out_item_o);
        end else begin
          want = due_results.pop_front();
          if (out_item_o !== want) note_error("result mismatch", want, out_item_o);
        end
      end
      if (burst_left > 0) begin
        burst_left = burst_left - 1;
        hold = 1'b1;
      end else if (burst_req != burst_seen) begin
        burst_seen = burst_req;
        burst_left = BurstCycles - 1;
        hold = 1'b1;
      end else begin
        hold = ($urandom_range(99) < rx_idle_pct);
      end
      out_stall <= hold;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic eom);
    in_item_t it;
    it.data_byte = b;
    it.end_of_message = eom;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], i == s.len() - 1);
  endtask

  task automatic drain(input int extra);
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Decode messages are mostly random base64 characters and up to two pads;
  // others carry a corrupted character, random noise or text after a pad.
  task automatic push_decode_message(output int count);
    logic [7:0] chars[16];
    int n;
    int kind;
    kind = $urandom_range(99);
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) chars[i] = b64_letter(6'($urandom_range(63)));
    for (int i = $urandom_range(0, 2); i > 0; i--) begin
      chars[n] = PadChar;
      n = n + 1;
    end
    if (kind < 15) begin
      chars[$urandom_range(0, n - 1)] = 8'($urandom_range(255));
    end else if (kind < 25) begin
      for (int i = 0; i < n; i++) chars[i] = 8'($urandom_range(255));
    end else if (kind < 32) begin
      chars[n] = PadChar;
      chars[n + 1] = 8'($urandom_range(255));
      n = n + 2;
    end
    for (int i = 0; i < n; i++) push_item(chars[i], i == n - 1);
    count = n;
  endtask

  task automatic run_chunk(input logic m, input bit pause_midway);
    int pushed;
    int n;
    bit paused;
    pushed = 0;
    paused = 0;
    while (pushed < ChunkItems) begin
      if (m == ModeEncode) begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) push_item(8'($urandom_range(255)), i == n - 1);
      end else begin
        push_decode_message(n);
      end
      pushed = pushed + n;
      if (pause_midway && !paused && pushed >= ChunkItems / 2) begin
        paused = 1;
        drain(0);
      end
    end
    // An unfinished message may be left open; the next mode write abandons it.
    for (int i = $urandom_range(0, 3); i > 0; i--) begin
      if (m == ModeEncode) push_item(8'($urandom_range(255)), 1'b0);
      else push_item(b64_letter(6'($urandom_range(63))), 1'b0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Encode: one leftover byte, two leftover bytes, and a full group.
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hA5, 1'b1);
    drain(SettleCycles);

    write_mode(ModeDecode);
    push_text("TWFu");
    push_text("+/9z");
    push_text("TQ=!");
    push_text("a*Zz");
    push_text("A$");
    push_text("=");
    push_text("B");
    drain(SettleCycles);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 88 : 0;
      rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 34 : 0;
      write_mode(ModeEncode);
      run_chunk(ModeEncode, ph == 1);
      if (ph == 0) burst_req = burst_req + 1;
      drain(SettleCycles);
      write_mode(ModeDecode);
      run_chunk(ModeDecode, ph == 0);
      if (ph == 2) burst_req = burst_req + 1;
      drain(SettleCycles);
    end

    if (error_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
